// ===== rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and codes of the byte stream tokenizer: the input byte item,
// the token result item and the bundle of results produced for one byte.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned SpanW    = 17;
  localparam int unsigned MaxRes   = 3;

  // token kinds
  localparam logic [2:0] KIND_END   = 3'd0;
  localparam logic [2:0] KIND_IDENT = 3'd1;
  localparam logic [2:0] KIND_LET   = 3'd2;
  localparam logic [2:0] KIND_INT   = 3'd3;
  localparam logic [2:0] KIND_COLON = 3'd4;
  localparam logic [2:0] KIND_EQUAL = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNEXPECTED = 2'd1;
  localparam logic [1:0] ST_TOO_MANY   = 2'd2;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       byte_valid;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]       token_kind;
    logic [SpanW-1:0] span_start;
    logic [SpanW-1:0] span_end;
    logic [1:0]       status;
    logic             source_done;
    logic             last_of_run;
  } token_item_t;

  // results of one byte: res[0] first, cnt of them valid
  typedef struct packed {
    logic [1:0]                   cnt;
    token_item_t [MaxRes-1:0]     res;
  } lex_out_t;

endpackage

// ===== rtl/byte_stream_tokenizer.sv =====
// An accepted byte waits in the input register, and the lexer step puts its
// results into the result queue that drives out_valid_o and out_item_o.
// Throughput: one byte per cycle while out_ready_i is high and each byte yields
// at most one result; more results per byte stall input until the queue drains.
// Input is taken while the input register is empty or can pass its byte on.
// Reset: clears lexer state, the input register valid flag and the result queue.
// ----------------------------------------------------------------------------
// byte_stream_tokenizer
// Streaming tokenizer: input register, single-pass lexer step and result queue.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer import bst_pkg::*; #(
  parameter int unsigned MAX_TOKEN_COUNT  = 4096,
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  byte_item_t  in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output token_item_t out_item_o
);

  logic       in_vld_q;
  byte_item_t in_q;
  logic       room;
  logic       advance;
  lex_out_t   lex_out;

  assign advance    = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
  end

  bst_lexer #(
    .MAX_TOKEN_COUNT (MAX_TOKEN_COUNT),
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .item_i(in_q),
    .out_o (lex_out)
  );

  bst_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (lex_out),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/bst_lexer.sv =====
// ----------------------------------------------------------------------------
// bst_lexer
// Per-source lexer state and the single-pass step that turns one byte item
// into up to three token results (closed run, single-byte token or error,
// end token).
// ----------------------------------------------------------------------------
module bst_lexer import bst_pkg::*; #(
  parameter int unsigned MAX_TOKEN_COUNT  = 4096,
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  byte_item_t item_i,
  output lex_out_t   out_o
);

  localparam int unsigned TcW  = $clog2(MAX_TOKEN_COUNT + 1);
  localparam int unsigned OffW = $clog2(MAX_SOURCE_BYTES + 1);

  localparam logic [TcW-1:0]  TcMax  = TcW'(MAX_TOKEN_COUNT);
  localparam logic [OffW-1:0] OffMax = OffW'(MAX_SOURCE_BYTES);

  typedef enum logic [2:0] {
    RUN_NONE  = 3'b001,
    RUN_IDENT = 3'b010,
    RUN_INT   = 3'b100
  } run_e;

  // keyword match progress
  typedef enum logic [4:0] {
    KW_NONE = 5'b00001,
    KW_L    = 5'b00010,
    KW_LE   = 5'b00100,
    KW_LET  = 5'b01000,
    KW_NOT  = 5'b10000
  } kw_e;

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic token_item_t mk(input logic [2:0] kind, input logic [SpanW-1:0] s,
                                     input logic [SpanW-1:0] e, input logic [1:0] st,
                                     input logic done);
    token_item_t t;
    t.token_kind  = kind;
    t.span_start  = s;
    t.span_end    = e;
    t.status      = st;
    t.source_done = done;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  run_e            run_q, run_d;
  logic [OffW-1:0] run_start_q, run_start_d;
  logic [OffW-1:0] off_q, off_d;
  logic [TcW-1:0]  tc_q, tc_d;
  kw_e             kw_q, kw_d;
  logic            failed_q, failed_d;

  always_comb begin : p_step
    token_item_t [MaxRes-1:0] r;
    logic [1:0]      n;
    logic            ok;
    logic            consumed;
    logic [7:0]      c;
    logic [2:0]      kind;
    logic [OffW:0]   off_p1;

    r           = '0;
    n           = 2'd0;
    ok          = 1'b1;
    consumed    = 1'b0;
    c           = item_i.byte_req;
    kind        = KIND_END;
    run_d       = run_q;
    run_start_d = run_start_q;
    off_d       = off_q;
    tc_d        = tc_q;
    kw_d        = kw_q;
    failed_d    = failed_q;
    off_p1      = {1'b0, off_q} + (OffW+1)'(1);

    if (!failed_q) begin
      if (item_i.byte_valid) begin
        if ((run_q == RUN_IDENT) && (is_word_start(c) || is_num_char(c))) begin
          consumed = 1'b1;
          if ((kw_q == KW_L) && (c == "e")) kw_d = KW_LE;
          else if ((kw_q == KW_LE) && (c == "t")) kw_d = KW_LET;
          else kw_d = KW_NOT;
        end else if ((run_q == RUN_INT) && is_num_char(c)) begin
          consumed = 1'b1;
        end else if (run_q != RUN_NONE) begin
          // close the open run
          kind  = (run_q == RUN_INT) ? KIND_INT : ((kw_q == KW_LET) ? KIND_LET : KIND_IDENT);
          run_d = RUN_NONE;
          kw_d  = KW_NONE;
          if (tc_d >= TcMax) begin
            r[n] = mk(KIND_END, SpanW'(run_start_q), SpanW'(off_q), ST_TOO_MANY, 1'b1);
            ok   = 1'b0;
            failed_d = 1'b1;
          end else begin
            r[n] = mk(kind, SpanW'(run_start_q), SpanW'(off_q), ST_OK, 1'b0);
            tc_d = tc_d + TcW'(1);
          end
          n = n + 2'd1;
        end

        if (ok && !consumed) begin
          if (is_blank(c)) begin
            // skip
          end else if (is_word_start(c)) begin
            run_d       = RUN_IDENT;
            run_start_d = off_q;
            if (c == "l") kw_d = KW_L;
            else kw_d = KW_NOT;
          end else if (is_num_char(c)) begin
            run_d       = RUN_INT;
            run_start_d = off_q;
          end else if ((c == ":") || (c == "=")) begin
            kind = (c == ":") ? KIND_COLON : KIND_EQUAL;
            if (tc_d >= TcMax) begin
              r[n] = mk(KIND_END, SpanW'(off_q), SpanW'(off_p1), ST_TOO_MANY, 1'b1);
              ok   = 1'b0;
              failed_d = 1'b1;
            end else begin
              r[n] = mk(kind, SpanW'(off_q), SpanW'(off_p1), ST_OK, 1'b0);
              tc_d = tc_d + TcW'(1);
            end
            n = n + 2'd1;
          end else begin
            r[n] = mk(KIND_END, SpanW'(off_q), SpanW'(off_p1), ST_UNEXPECTED, 1'b1);
            n    = n + 2'd1;
            ok   = 1'b0;
            failed_d = 1'b1;
          end
        end

        if (ok && (off_q < OffMax)) off_d = off_p1[OffW-1:0];
      end

      if (ok && item_i.last_byte) begin
        if (run_d != RUN_NONE) begin
          kind = (run_d == RUN_INT) ? KIND_INT : ((kw_d == KW_LET) ? KIND_LET : KIND_IDENT);
          if (tc_d >= TcMax) begin
            r[n] = mk(KIND_END, SpanW'(run_start_d), SpanW'(off_d), ST_TOO_MANY, 1'b1);
            ok   = 1'b0;
          end else begin
            r[n] = mk(kind, SpanW'(run_start_d), SpanW'(off_d), ST_OK, 1'b0);
            tc_d = tc_d + TcW'(1);
          end
          n = n + 2'd1;
        end
        if (ok) begin
          if (tc_d >= TcMax) begin
            r[n] = mk(KIND_END, SpanW'(off_d), SpanW'(off_d), ST_TOO_MANY, 1'b1);
          end else begin
            r[n] = mk(KIND_END, SpanW'(off_d), SpanW'(off_d), ST_OK, 1'b1);
          end
          n = n + 2'd1;
        end
      end
    end

    // the end of a source returns all state to its reset values
    if (item_i.last_byte) begin
      run_d       = RUN_NONE;
      run_start_d = '0;
      off_d       = '0;
      tc_d        = '0;
      kw_d        = KW_NONE;
      failed_d    = 1'b0;
    end

    if (n != 2'd0) r[n - 2'd1].last_of_run = 1'b1;

    out_o.res = r;
    out_o.cnt = fire_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= RUN_NONE;
      run_start_q <= '0;
      off_q       <= '0;
      tc_q        <= '0;
      kw_q        <= KW_NONE;
      failed_q    <= 1'b0;
    end else if (fire_i) begin
      run_q       <= run_d;
      run_start_q <= run_start_d;
      off_q       <= off_d;
      tc_q        <= tc_d;
      kw_q        <= kw_d;
      failed_q    <= failed_d;
    end
  end

endmodule

// ===== rtl/bst_res_fifo.sv =====
// ----------------------------------------------------------------------------
// bst_res_fifo
// Four-entry result queue: takes up to three results per cycle from the
// lexer and hands them out one per cycle on the output handshake.
// ----------------------------------------------------------------------------
module bst_res_fifo import bst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lex_out_t    wr_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output token_item_t out_item_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  token_item_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full burst of results
  assign room_o      = (cnt_q <= CntW'(Depth - MaxRes));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(wr_i.cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(wr_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < wr_i.cnt) mem_q[wr_ptr_q + PtrW'(k)] <= wr_i.res[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/bst_checker.sv =====
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks of the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bst_checker import bst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input byte_item_t  in_item_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input token_item_t out_item_o
);

  // hold a waiting byte item
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("waiting byte item dropped or changed");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

  // an error always closes the source and the burst of its byte
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_OK) |->
      out_item_o.source_done && out_item_o.last_of_run &&
      (out_item_o.token_kind == KIND_END))
    else $error("error result not final");

  // the end of a source is the last result of its byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.source_done |-> out_item_o.last_of_run)
    else $error("source done before end of burst");

  // only end tokens and errors finish a source
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.source_done |-> (out_item_o.token_kind == KIND_END))
    else $error("source done on a non-end token");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (.*);
